// ===== rtl/cotc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Charger output tick controller package
// Shared types, register map and the constant tables of the test sequence.
// ----------------------------------------------------------------------------
package cotc_pkg;

	localparam int unsigned ADDR_W = 4;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_UNLOCK_CODE   = 2'd0;
	localparam logic [1:0] REG_PULL_IN_TICKS = 2'd1;
	localparam logic [1:0] REG_ECONOMY_DUTY  = 2'd2;

	localparam logic [15:0] UNLOCK_CODE_RST   = 16'd3411;
	localparam logic [7:0]  PULL_IN_TICKS_RST = 8'd66;
	localparam logic [15:0] ECONOMY_DUTY_RST  = 16'd40000;

	localparam logic [4:0]  TEST_OFF        = 5'd0;
	localparam logic [4:0]  TEST_FIRST_STEP = 5'd1;
	localparam logic [4:0]  TEST_LAST_STEP  = 5'd23;
	localparam logic [4:0]  RGB_LAST_STEP   = 5'd8;
	localparam logic [4:0]  BRIDGE_FIRST    = 5'd9;
	localparam logic [4:0]  BRIDGE_LAST     = 5'd17;
	localparam logic [4:0]  CONT_FIRST      = 5'd18;
	localparam logic [3:0]  PHASE_RELOAD    = 4'd10;
	localparam logic [3:0]  ALIVE_THRESHOLD = 4'd5;
	localparam logic [7:0]  PULL_IN_MAX     = 8'd255;
	localparam logic [15:0] FULL_DUTY       = 16'd65535;

	// LED codes: bit0 red, bit1 green, bit2 blue.
	localparam logic [2:0] LED_OFF   = 3'd0;
	localparam logic [2:0] LED_RED   = 3'd1;
	localparam logic [2:0] LED_GREEN = 3'd2;
	localparam logic [2:0] LED_BLUE  = 3'd4;
	localparam logic [2:0] LED_CYAN  = 3'd6;
	localparam logic [2:0] LED_WHITE = 3'd7;

	localparam logic [2:0] RGB_SEQ [8] = '{
		LED_RED, LED_OFF, LED_GREEN, LED_OFF, LED_BLUE, LED_OFF, LED_WHITE, LED_OFF
	};
	localparam logic [15:0] BRIDGE_A_SEQ [9] = '{
		16'd0, 16'd6500, 16'd32768, 16'd65535, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0
	};
	localparam logic [15:0] BRIDGE_B_SEQ [9] = '{
		16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd6500, 16'd32768, 16'd65535, 16'd0
	};
	localparam logic [15:0] CONT_A_SEQ [6] = '{
		16'd0, 16'd65535, 16'd50000, 16'd0, 16'd0, 16'd0
	};
	localparam logic [15:0] CONT_B_SEQ [6] = '{
		16'd0, 16'd0, 16'd0, 16'd65535, 16'd50000, 16'd0
	};

	typedef struct packed {
		logic [15:0] unlock_code;
		logic [7:0]  pull_in_ticks;
		logic [15:0] economy_duty;
	} cotc_cfg_t;

	typedef struct packed {
		logic [4:0]  test_step;
		logic [3:0]  phase_timer;
		logic [7:0]  pull_in_count;
		logic [7:0]  blink_divider;
		logic [2:0]  rgb_hold;
		logic        alive_hold;
		logic [15:0] bridge_a;
		logic [15:0] bridge_b;
		logic [15:0] contactor_a;
		logic [15:0] contactor_b;
	} cotc_state_t;

	typedef struct packed {
		logic [15:0] checkpoint;
		logic [15:0] button_code;
		logic        contactor_request;
	} cotc_item_t;

endpackage

// ===== rtl/cotc_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding unlock code, pull-in length and economy duty.
// ----------------------------------------------------------------------------
module cotc_regs
	import cotc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cotc_cfg_t         cfg
);

	cotc_cfg_t  cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.unlock_code   <= UNLOCK_CODE_RST;
			cfg_q.pull_in_ticks <= PULL_IN_TICKS_RST;
			cfg_q.economy_duty  <= ECONOMY_DUTY_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_UNLOCK_CODE:   cfg_q.unlock_code   <= pwdata[15:0];
				REG_PULL_IN_TICKS: cfg_q.pull_in_ticks <= pwdata[7:0];
				REG_ECONOMY_DUTY:  cfg_q.economy_duty  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_UNLOCK_CODE:   prdata = {16'd0, cfg_q.unlock_code};
			REG_PULL_IN_TICKS: prdata = {24'd0, cfg_q.pull_in_ticks};
			REG_ECONOMY_DUTY:  prdata = {16'd0, cfg_q.economy_duty};
			default:           prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/cotc_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tick next-state logic
// LED mapping, contactor pull-in control and the output test sequencer.
// ----------------------------------------------------------------------------
module cotc_step
	import cotc_pkg::*;
(
	input  cotc_state_t cur,
	input  cotc_cfg_t   cfg,
	input  cotc_item_t  item,
	output cotc_state_t nxt
);

	logic [7:0]  div_inc;
	logic [7:0]  pic_inc;
	logic [15:0] cp;
	logic [4:0]  step_go;
	logic [4:0]  step_inc;
	logic [3:0]  phase_dec;
	logic [3:0]  bridge_off;
	logic [2:0]  cont_off;

	assign cp        = item.checkpoint;
	assign div_inc   = cur.blink_divider + 8'd1;
	assign pic_inc   = (cur.pull_in_count < PULL_IN_MAX) ? cur.pull_in_count + 8'd1
	                                                     : cur.pull_in_count;
	assign phase_dec = cur.phase_timer - 4'd1;

	always_comb begin
		nxt        = cur;
		step_go    = cur.test_step;
		step_inc   = 5'd0;
		bridge_off = 4'd0;
		cont_off   = 3'd0;

		// Normal mode: LED pattern and contactor drive.
		if (cur.test_step == TEST_OFF) begin
			nxt.blink_divider = div_inc;
			if (cp < 16'd100)
				nxt.rgb_hold = LED_WHITE;
			else if (cp < 16'd150)
				nxt.rgb_hold = LED_GREEN;
			else if (cp > 16'd150 && cp <= 16'd530)
				nxt.rgb_hold = div_inc[2] ? LED_GREEN : LED_OFF;
			else if (cp >= 16'd540 && cp < 16'd560)
				nxt.rgb_hold = div_inc[1] ? LED_GREEN : LED_OFF;
			else if (cp >= 16'd560 && cp < 16'd700)
				nxt.rgb_hold = div_inc[1] ? LED_BLUE : LED_OFF;
			else if (cp >= 16'd700 && cp < 16'd800)
				nxt.rgb_hold = LED_BLUE;
			else if (cp >= 16'd800 && cp < 16'd900)
				nxt.rgb_hold = div_inc[0] ? LED_BLUE : LED_GREEN;
			else if (cp == 16'd900)
				nxt.rgb_hold = LED_CYAN;
			else if (cp > 16'd1000)
				nxt.rgb_hold = LED_RED;

			if (!item.contactor_request) begin
				nxt.pull_in_count = 8'd0;
				nxt.contactor_a   = 16'd0;
				nxt.contactor_b   = 16'd0;
			end else begin
				nxt.pull_in_count = pic_inc;
				nxt.contactor_a   = (pic_inc < cfg.pull_in_ticks) ? FULL_DUTY
				                                                  : cfg.economy_duty;
				nxt.contactor_b   = nxt.contactor_a;
			end
		end

		// Phase timer and test sequencer.
		if (cur.phase_timer != 4'd0) begin
			nxt.phase_timer = phase_dec;
			nxt.alive_hold  = (phase_dec > ALIVE_THRESHOLD);
		end else begin
			nxt.phase_timer = PHASE_RELOAD;
			if (item.button_code == cfg.unlock_code && cur.test_step == TEST_OFF)
				step_go = TEST_FIRST_STEP;
			if (step_go != TEST_OFF) begin
				bridge_off = 4'(step_go - BRIDGE_FIRST);
				cont_off   = 3'(step_go - CONT_FIRST);
				if (step_go <= RGB_LAST_STEP) begin
					nxt.rgb_hold = RGB_SEQ[3'(step_go - TEST_FIRST_STEP)];
				end else if (step_go <= BRIDGE_LAST) begin
					nxt.bridge_a = BRIDGE_A_SEQ[bridge_off];
					nxt.bridge_b = BRIDGE_B_SEQ[bridge_off];
				end else if (step_go <= TEST_LAST_STEP) begin
					nxt.contactor_a = CONT_A_SEQ[cont_off];
					nxt.contactor_b = CONT_B_SEQ[cont_off];
				end
				step_inc = step_go + 5'd1;
				nxt.test_step = (step_inc > TEST_LAST_STEP || step_inc == TEST_OFF)
				              ? TEST_FIRST_STEP : step_inc;
			end
		end
	end

endmodule

// ===== rtl/charger_output_tick_controller_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Charger output tick controller
// Per-tick LED pattern, contactor PWM and output test sequencer with an
// APB-style configuration port and stream input and output channels.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item is held in the input register, then its result
// in the result register until the receiver takes it.
// Throughput: one item per cycle while the receiver keeps up; the tick state
// recurrence is combinational compares and counter updates in cotc_step. Input
// stalls only while both registers are full and the receiver holds m_tready low.
// Reset: arst_n clears all tick state, both pipeline valids and loads the
// registers with unlock code 3411, pull-in 66 ticks and economy duty 40000.
// ----------------------------------------------------------------------------
module charger_output_tick_controller_unit
	import cotc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// Configuration port.
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	// Tick items in.
	input  logic              s_tvalid,
	output logic              s_tready,
	// [15:0] checkpoint, [31:16] button_code, [32] contactor_request, [39:33] zero
	input  logic [39:0]       s_tdata,
	// Results out.
	output logic              m_tvalid,
	input  logic              m_tready,
	// [2:0] rgb_leds, [3] alive_led, [19:4] bridge_duty_a, [35:20] bridge_duty_b,
	// [51:36] contactor_duty_a, [67:52] contactor_duty_b, [68] test_active,
	// [71:69] zero
	output logic [71:0]       m_tdata
);

	cotc_cfg_t   cfg;
	cotc_state_t state_q;
	cotc_state_t state_d;
	cotc_item_t  item_s1;
	logic        valid_s1;
	logic        valid_s2;
	logic        adv_s1;
	logic [71:0] data_s2;

	cotc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The item in stage one is applied to the tick state when it moves into
	// the result register, so each item sees the state left by the one before.
	assign adv_s1   = valid_s1 & (~valid_s2 | m_tready);
	assign s_tready = ~valid_s1 | adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Input payload register; no reset needed.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.checkpoint        <= s_tdata[15:0];
			item_s1.button_code       <= s_tdata[31:16];
			item_s1.contactor_request <= s_tdata[32];
		end
	end

	cotc_step u_step (
		.cur  (state_q),
		.cfg  (cfg),
		.item (item_s1),
		.nxt  (state_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1)
				state_q <= state_d;
			if (adv_s1)
				valid_s2 <= 1'b1;
			else if (m_tready)
				valid_s2 <= 1'b0;
		end
	end

	// Result register: the held outputs after this tick.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			data_s2 <= {3'd0, (state_d.test_step != TEST_OFF),
			            state_d.contactor_b, state_d.contactor_a,
			            state_d.bridge_b, state_d.bridge_a,
			            state_d.alive_hold, state_d.rgb_hold};
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;

	// Once started, the test sequence never stops.
	a_test_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.test_step != TEST_OFF |=> state_q.test_step != TEST_OFF)
		else $error("test sequence left running state");

	// The step counter stays within the defined sequence.
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.test_step <= TEST_LAST_STEP)
		else $error("test step out of range");

	// Phase timer never exceeds its reload value.
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase_timer <= PHASE_RELOAD)
		else $error("phase timer out of range");

	// While the sequence runs, the pull-in counter and divider are frozen.
	a_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.test_step != TEST_OFF |=>
		state_q.pull_in_count == $past(state_q.pull_in_count) &&
		state_q.blink_divider == $past(state_q.blink_divider))
		else $error("normal logic advanced during test sequence");

	// State only changes when an item moves into the result register.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(state_q))
		else $error("tick state changed without an item");

endmodule

// ===== test/charger_output_tick_controller_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Charger output tick controller testbench
// Sends tick items through the stream input, predicts every result with an
// independent model of the LED, contactor and output test logic, and checks
// each result field by field. The register settings change between phases,
// the receiver stalls the block once for a long stretch, and the run ends in
// the output test sequence, which locks the block for good.
// ----------------------------------------------------------------------------
module charger_output_tick_controller_unit_test
	import cotc_pkg::*;
();

	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int CORNER_COUNT    = 23;

	// Range edges of the LED mapping, the gaps between ranges included.
	localparam logic [15:0] CP_CORNERS [CORNER_COUNT] = '{
		16'd0, 16'd99, 16'd100, 16'd149, 16'd150, 16'd151, 16'd530, 16'd531,
		16'd535, 16'd539, 16'd540, 16'd559, 16'd560, 16'd699, 16'd700, 16'd799,
		16'd800, 16'd899, 16'd900, 16'd901, 16'd1000, 16'd1001, 16'd65535
	};

	typedef enum {TICK_SWEEP, TICK_RANDOM, TICK_PROBE, TICK_SEQUENCE} tick_mode_e;

	// Result word, most significant field first.
	typedef struct packed {
		logic [2:0]  pad;
		logic        test_active;
		logic [15:0] contactor_b;
		logic [15:0] contactor_a;
		logic [15:0] bridge_b;
		logic [15:0] bridge_a;
		logic        alive_led;
		logic [2:0]  rgb_leds;
	} tick_outputs_t;

	class output_tick_scoreboard;
		logic [15:0] unlock_code   = UNLOCK_CODE_RST;
		logic [7:0]  pull_in_ticks = PULL_IN_TICKS_RST;
		logic [15:0] economy_duty  = ECONOMY_DUTY_RST;

		logic [4:0]  test_step     = TEST_OFF;
		logic [3:0]  phase_timer   = '0;
		logic [7:0]  pull_in_count = '0;
		logic [7:0]  blink_divider = '0;
		logic [2:0]  rgb           = LED_OFF;
		logic        alive         = 1'b0;
		logic [15:0] bridge_a      = '0;
		logic [15:0] bridge_b      = '0;
		logic [15:0] contactor_a   = '0;
		logic [15:0] contactor_b   = '0;

		tick_outputs_t expected_outputs [$];
		int ticks_noted     = 0;
		int outputs_checked = 0;
		int sequence_wraps  = 0;
		int errors          = 0;

		function void set_reg(logic [1:0] index, logic [31:0] value);
			case (index)
				REG_UNLOCK_CODE:   unlock_code = value[15:0];
				REG_PULL_IN_TICKS: pull_in_ticks = value[7:0];
				REG_ECONOMY_DUTY:  economy_duty = value[15:0];
				default: ;
			endcase
		endfunction

		function void note_tick(cotc_item_t tick);
			tick_outputs_t out;
			logic [15:0] cp;
			cp = tick.checkpoint;
			// The LED and contactor logic only run until the test sequence starts.
			if (test_step == TEST_OFF) begin
				blink_divider = blink_divider + 8'd1;
				if (cp < 16'd100)
					rgb = LED_WHITE;
				else if (cp < 16'd150)
					rgb = LED_GREEN;
				else if (cp > 16'd150 && cp <= 16'd530)
					rgb = blink_divider[2] ? LED_GREEN : LED_OFF;
				else if (cp >= 16'd540 && cp < 16'd560)
					rgb = blink_divider[1] ? LED_GREEN : LED_OFF;
				else if (cp >= 16'd560 && cp < 16'd700)
					rgb = blink_divider[1] ? LED_BLUE : LED_OFF;
				else if (cp >= 16'd700 && cp < 16'd800)
					rgb = LED_BLUE;
				else if (cp >= 16'd800 && cp < 16'd900)
					rgb = blink_divider[0] ? LED_BLUE : LED_GREEN;
				else if (cp == 16'd900)
					rgb = LED_CYAN;
				else if (cp > 16'd1000)
					rgb = LED_RED;
				// Checkpoints in the gaps keep the previous color.

				if (!tick.contactor_request) begin
					contactor_a = '0;
					contactor_b = '0;
					pull_in_count = '0;
				end else begin
					if (pull_in_count < PULL_IN_MAX)
						pull_in_count++;
					contactor_a = (pull_in_count < pull_in_ticks) ? FULL_DUTY : economy_duty;
					contactor_b = contactor_a;
				end
			end

			if (phase_timer != 4'd0) begin
				phase_timer--;
				alive = phase_timer > ALIVE_THRESHOLD;
			end else begin
				phase_timer = PHASE_RELOAD;
				if (tick.button_code == unlock_code && test_step == TEST_OFF)
					test_step = TEST_FIRST_STEP;
				if (test_step != TEST_OFF) begin
					case (test_step)
						5'd1: rgb = LED_RED;
						5'd2, 5'd4, 5'd6, 5'd8: rgb = LED_OFF;
						5'd3: rgb = LED_GREEN;
						5'd5: rgb = LED_BLUE;
						5'd7: rgb = LED_WHITE;
						5'd9, 5'd13, 5'd17: {bridge_a, bridge_b} = '0;
						5'd10: {bridge_a, bridge_b} = {16'd6500, 16'd0};
						5'd11: {bridge_a, bridge_b} = {16'd32768, 16'd0};
						5'd12: {bridge_a, bridge_b} = {16'd65535, 16'd0};
						5'd14: {bridge_a, bridge_b} = {16'd0, 16'd6500};
						5'd15: {bridge_a, bridge_b} = {16'd0, 16'd32768};
						5'd16: {bridge_a, bridge_b} = {16'd0, 16'd65535};
						5'd18, 5'd23: {contactor_a, contactor_b} = '0;
						5'd19: {contactor_a, contactor_b} = {16'd65535, 16'd0};
						5'd20: {contactor_a, contactor_b} = {16'd50000, 16'd0};
						5'd21: {contactor_a, contactor_b} = {16'd0, 16'd65535};
						5'd22: {contactor_a, contactor_b} = {16'd0, 16'd50000};
						default: ;
					endcase
					if (test_step >= TEST_LAST_STEP) begin
						test_step = TEST_FIRST_STEP;
						sequence_wraps++;
					end else begin
						test_step++;
					end
				end
			end

			out = '0;
			out.rgb_leds = rgb;
			out.alive_led = alive;
			out.bridge_a = bridge_a;
			out.bridge_b = bridge_b;
			out.contactor_a = contactor_a;
			out.contactor_b = contactor_b;
			out.test_active = test_step != TEST_OFF;
			expected_outputs.push_back(out);
			ticks_noted++;
		endfunction

		function void report(string field, logic [15:0] want, logic [15:0] got);
			$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
			errors++;
		endfunction

		function void check_outputs(logic [71:0] word);
			tick_outputs_t got;
			tick_outputs_t want;
			got = tick_outputs_t'(word);
			if (expected_outputs.size() == 0) begin
				$display("%0t: result %h arrived with no tick pending", $time, word);
				errors++;
				return;
			end
			want = expected_outputs.pop_front();
			outputs_checked++;
			if (got.rgb_leds !== want.rgb_leds)
				report("rgb_leds", 16'(want.rgb_leds), 16'(got.rgb_leds));
			if (got.alive_led !== want.alive_led)
				report("alive_led", 16'(want.alive_led), 16'(got.alive_led));
			if (got.bridge_a !== want.bridge_a)
				report("bridge_duty_a", want.bridge_a, got.bridge_a);
			if (got.bridge_b !== want.bridge_b)
				report("bridge_duty_b", want.bridge_b, got.bridge_b);
			if (got.contactor_a !== want.contactor_a)
				report("contactor_duty_a", want.contactor_a, got.contactor_a);
			if (got.contactor_b !== want.contactor_b)
				report("contactor_duty_b", want.contactor_b, got.contactor_b);
			if (got.test_active !== want.test_active)
				report("test_active", 16'(want.test_active), 16'(got.test_active));
			if (got.pad !== want.pad)
				report("padding", 16'(want.pad), 16'(got.pad));
		endfunction
	endclass

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              psel     = 1'b0;
	logic              penable  = 1'b0;
	logic              pwrite   = 1'b0;
	logic [ADDR_W-1:0] paddr    = '0;
	logic [31:0]       pwdata   = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	// [15:0] checkpoint, [31:16] button_code, [32] contactor_request, [39:33] zero
	logic [39:0]       s_tdata  = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	// [2:0] rgb_leds, [3] alive_led, [19:4] bridge_duty_a, [35:20] bridge_duty_b,
	// [51:36] contactor_duty_a, [67:52] contactor_duty_b, [68] test_active,
	// [71:69] zero
	logic [71:0]       m_tdata;

	output_tick_scoreboard sb;

	bit no_idle         = 1'b0;
	bit hold_off_wanted = 1'b0;
	bit hold_off_done   = 1'b0;
	int hold_off_left   = 0;
	int quiet_cycles    = 0;
	int sweep_index     = 0;
	int settings_used   = 1;
	bit req_level       = 1'b0;
	int req_left        = 0;

	charger_output_tick_controller_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #2 clk = ~clk;

	// Builds the next tick. The contactor request comes in runs, some of them
	// long enough to pass the largest pull-in count and reach saturation.
	function automatic cotc_item_t make_tick(tick_mode_e mode);
		cotc_item_t tick;
		int pick;
		if (req_left == 0) begin
			req_level = $urandom_range(0, 3) != 0;
			req_left = ($urandom_range(0, 3) == 0) ? $urandom_range(200, 320)
				: $urandom_range(1, 20);
		end
		req_left--;
		tick.contactor_request = req_level;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			tick.checkpoint = 16'($urandom);
		else if (pick == 1)
			tick.checkpoint = CP_CORNERS[$urandom_range(0, CORNER_COUNT - 1)];
		else
			tick.checkpoint = 16'($urandom_range(0, 1100));
		// Outside the unlock phases the code never matches, so the block
		// stays in normal mode.
		tick.button_code = 16'($urandom);
		if (tick.button_code == sb.unlock_code)
			tick.button_code ^= 16'h0001;
		case (mode)
			TICK_SWEEP: begin
				tick.checkpoint = CP_CORNERS[sweep_index % CORNER_COUNT];
				tick.button_code = sweep_index[0] ? 16'hFFFF : 16'h0000;
				tick.contactor_request = sweep_index[1];
				sweep_index++;
			end
			TICK_PROBE: begin
				// The right code while the phase timer runs is ignored; a code
				// one bit off lands on the ticks where the timer is zero.
				if (sb.phase_timer != 4'd0 && $urandom_range(0, 2) == 0)
					tick.button_code = sb.unlock_code;
				else if (sb.phase_timer == 4'd0 && $urandom_range(0, 1) == 0)
					tick.button_code = sb.unlock_code ^ (16'h0001 << $urandom_range(0, 15));
			end
			TICK_SEQUENCE: begin
				if (sb.test_step == TEST_OFF)
					tick.button_code = sb.unlock_code;
			end
			default: ;
		endcase
		return tick;
	endfunction

	task automatic send_ticks(input int count, input tick_mode_e mode);
		cotc_item_t offered;
		int taken;
		bit holding;
		taken = 0;
		holding = 1'b0;
		while (taken < count) begin
			if (!holding) begin
				if (!no_idle && $urandom_range(0, 99) < 6) begin
					s_tvalid <= 1'b0;
				end else begin
					offered = make_tick(mode);
					s_tdata <= {7'd0, offered.contactor_request, offered.button_code,
						offered.checkpoint};
					s_tvalid <= 1'b1;
					holding = 1'b1;
				end
			end
			@(posedge clk);
			if (s_tvalid && s_tready) begin
				sb.note_tick(offered);
				taken++;
				holding = 1'b0;
			end
		end
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// Waits until every expected result has arrived, then idles before returning.
	task automatic settle();
		while (sb.expected_outputs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({index, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(index, value);
	endtask

	task automatic configure(input logic [31:0] unlock, input logic [31:0] pull_in,
			input logic [31:0] economy);
		write_reg(REG_UNLOCK_CODE, unlock);
		write_reg(REG_PULL_IN_TICKS, pull_in);
		write_reg(REG_ECONOMY_DUTY, economy);
		settings_used++;
	endtask

	// Result side: checks every accepted result, idles at random and takes
	// one long hold-off when asked, so the block fills and stalls its input.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_outputs(m_tdata);
			if (hold_off_left > 0) begin
				hold_off_left--;
				m_tready <= 1'b0;
			end else if (hold_off_wanted && !hold_off_done) begin
				hold_off_left = HOLD_OFF_CYCLES;
				hold_off_done = 1'b1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= no_idle || $urandom_range(0, 99) >= 6;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("[charger_output_tick_controller_unit] ERROR");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: range edges first, then random ticks.
		send_ticks(CORNER_COUNT, TICK_SWEEP);
		send_ticks(150, TICK_RANDOM);
		settle();

		// Pull-in of zero: economy duty from the first tick on. No idling here.
		configure(32'h0000_0000, 32'd0, 32'd0);
		no_idle = 1'b1;
		send_ticks(150, TICK_RANDOM);
		no_idle = 1'b0;
		settle();

		// Upper extremes, with the long receiver hold-off.
		configure(32'h0000_FFFF, 32'd255, 32'h0000_FFFF);
		hold_off_wanted = 1'b1;
		send_ticks(150, TICK_RANDOM);
		settle();

		repeat (2) begin
			configure($urandom, $urandom, $urandom);
			send_ticks(120, TICK_RANDOM);
			settle();
		end

		// Near misses of the unlock code, then the test sequence itself,
		// long enough to wrap around more than once.
		configure($urandom, 32'd1, $urandom);
		send_ticks(40, TICK_PROBE);
		send_ticks(520, TICK_SEQUENCE);
		settle();

		$display("Checked %0d of %0d tick results over %0d register settings.",
			sb.outputs_checked, sb.ticks_noted, settings_used);
		$display("LED range edges, pull-in extremes, a %0d-cycle stall, %0d test sequence wraps.",
			HOLD_OFF_CYCLES, sb.sequence_wraps);
		if (sb.errors == 0)
			$display("[charger_output_tick_controller_unit] OK");
		else
			$display("[charger_output_tick_controller_unit] ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/cotc_pkg.sv
rtl/cotc_regs.sv
rtl/cotc_step.sv
rtl/charger_output_tick_controller_unit.sv
test/charger_output_tick_controller_unit_test.sv
